### sv/slid_pkg.sv
// ----------------------------------------------------------------------------
// slid_pkg: shared types and codes of the sorted list
// Status codes, request codes and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package slid_pkg;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	// status codes of a result word
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_REMOVED  = 2'd1;
	localparam logic [1:0] ST_MISS     = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic       load;          // latch request word
		logic       idx_top;       // index to last occupied entry
		logic       idx_zero;      // index to entry 0
		logic       idx_dec;
		logic       idx_inc;
		logic       rd_top;        // read last occupied entry instead of index
		logic       wr_up_data;    // entry[idx+1] <= read data
		logic       wr_up_val;     // entry[idx+1] <= request value
		logic       wr_at_val;     // entry[idx] <= request value
		logic       wr_down_data;  // entry[idx-1] <= read data
		logic       set_found;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       stat_en;
		logic [1:0] stat_code;
		logic       cap_min;
		logic       cap_max;
		logic       clr_minmax;
	} slid_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_delete;
		logic empty;
		logic full;
		logic out_range;  // value below min or above max
		logic ge;         // read data >= value
		logic eq;         // read data == value
		logic found;
		logic at_last;    // index on last occupied entry
		logic at_zero;    // index on entry 0
	} slid_sts_t;

endpackage

### sv/slid_datapath.sv
// ----------------------------------------------------------------------------
// slid_datapath: storage and arithmetic of the sorted list
// Holds the value memory, the entry count, the running index, the cached
// minimum and maximum and the status of the current word.
// ----------------------------------------------------------------------------
module slid_datapath
	import slid_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slid_cmd_t          cmd,
	output slid_sts_t          sts,
	input  logic               req_type,
	input  logic signed [31:0] value,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic signed [31:0] min_value,
	output logic signed [31:0] max_value
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic signed [31:0] val_q;
	logic               del_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic               found_q;
	logic [1:0]         status_q;
	logic signed [31:0] min_q;
	logic signed [31:0] max_q;

	logic [AW-1:0]      top;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               wr_en;

	assign top     = AW'(count_q - CW'(1));
	assign rd_addr = cmd.rd_top ? top : idx_q;

	// write port select
	always_comb begin
		wr_en   = cmd.wr_up_data | cmd.wr_up_val | cmd.wr_at_val | cmd.wr_down_data;
		wr_data = (cmd.wr_up_data | cmd.wr_down_data) ? rdata_q : val_q;
		if (cmd.wr_up_data || cmd.wr_up_val) begin
			wr_addr = idx_q + AW'(1);
		end else if (cmd.wr_down_data) begin
			wr_addr = idx_q - AW'(1);
		end else begin
			wr_addr = idx_q;
		end
	end

	// value memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
			del_q <= req_type;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_MISS;
			min_q    <= '0;
			max_q    <= '0;
		end else begin
			// entry count
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			// running index
			if (cmd.idx_top) begin
				idx_q <= top;
			end else if (cmd.idx_zero) begin
				idx_q <= '0;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - AW'(1);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			// match seen during delete scan
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.stat_en) begin
				status_q <= cmd.stat_code;
			end
			// cached extremes
			if (cmd.clr_minmax) begin
				min_q <= '0;
				max_q <= '0;
			end else begin
				if (cmd.cap_min) begin
					min_q <= rdata_q;
				end
				if (cmd.cap_max) begin
					max_q <= rdata_q;
				end
			end
		end
	end

	// status toward the controller
	always_comb begin
		sts.is_delete = (del_q == REQ_DELETE);
		sts.empty     = (count_q == '0);
		sts.full      = (count_q == CW'(DEPTH));
		sts.out_range = (val_q < min_q) || (val_q > max_q);
		sts.ge        = (rdata_q >= val_q);
		sts.eq        = (rdata_q == val_q);
		sts.found     = found_q;
		sts.at_last   = (idx_q == top);
		sts.at_zero   = (idx_q == '0);
	end

	assign status    = status_q;
	assign count     = 5'(count_q);
	assign min_value = min_q;
	assign max_value = max_q;

endmodule

### sv/slid_ctrl.sv
// ----------------------------------------------------------------------------
// slid_ctrl: sequencer of the sorted list
// Walks the memory one entry per read/check pair: downward for an insert,
// shifting larger or equal entries up, upward for a delete, closing the gap
// behind the match, then reads both ends for min and max, or clears both if empty.
// ----------------------------------------------------------------------------
module slid_ctrl
	import slid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output slid_cmd_t cmd,
	input  slid_sts_t sts
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECIDE  = 4'd1;
	localparam logic [3:0] S_INS_RD  = 4'd2;
	localparam logic [3:0] S_INS_CHK = 4'd3;
	localparam logic [3:0] S_INS_PUT = 4'd4;
	localparam logic [3:0] S_DEL_RD  = 4'd5;
	localparam logic [3:0] S_DEL_CHK = 4'd6;
	localparam logic [3:0] S_MIN_RD  = 4'd7;
	localparam logic [3:0] S_MAX_RD  = 4'd8;
	localparam logic [3:0] S_MAX_CAP = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.is_delete) begin
					if (sts.full) begin
						cmd.stat_en   = 1'b1;
						cmd.stat_code = ST_FULL;
						state_d       = S_DONE;
					end else if (sts.empty) begin
						cmd.idx_zero = 1'b1;
						state_d      = S_INS_PUT;
					end else begin
						cmd.idx_top = 1'b1;
						state_d     = S_INS_RD;
					end
				end else if (sts.empty || sts.out_range) begin
					cmd.stat_en   = 1'b1;
					cmd.stat_code = ST_MISS;
					state_d       = S_DONE;
				end else begin
					cmd.idx_zero = 1'b1;
					state_d      = S_DEL_RD;
				end
			end
			S_INS_RD: begin
				state_d = S_INS_CHK;
			end
			S_INS_CHK: begin
				// shift larger or equal entries up, drop the value above the first smaller one
				if (sts.ge) begin
					cmd.wr_up_data = 1'b1;
					if (sts.at_zero) begin
						state_d = S_INS_PUT;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = S_INS_RD;
					end
				end else begin
					cmd.wr_up_val = 1'b1;
					cmd.cnt_inc   = 1'b1;
					cmd.stat_en   = 1'b1;
					cmd.stat_code = ST_INSERTED;
					cmd.idx_zero  = 1'b1;
					state_d       = S_MIN_RD;
				end
			end
			S_INS_PUT: begin
				cmd.wr_at_val = 1'b1;
				cmd.cnt_inc   = 1'b1;
				cmd.stat_en   = 1'b1;
				cmd.stat_code = ST_INSERTED;
				cmd.idx_zero  = 1'b1;
				state_d       = S_MIN_RD;
			end
			S_DEL_RD: begin
				state_d = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				// after the first match every entry moves down one place
				if (sts.found) begin
					cmd.wr_down_data = 1'b1;
				end else if (sts.eq) begin
					cmd.set_found = 1'b1;
				end
				if (sts.at_last) begin
					cmd.stat_en  = 1'b1;
					cmd.idx_zero = 1'b1;
					if (sts.found || sts.eq) begin
						cmd.cnt_dec   = 1'b1;
						cmd.stat_code = ST_REMOVED;
					end else begin
						cmd.stat_code = ST_MISS;
					end
					state_d = S_MIN_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_DEL_RD;
				end
			end
			S_MIN_RD: begin
				if (sts.empty) begin
					cmd.clr_minmax = 1'b1;
					state_d        = S_DONE;
				end else begin
					state_d = S_MAX_RD;
				end
			end
			S_MAX_RD: begin
				cmd.rd_top  = 1'b1;
				cmd.cap_min = 1'b1;
				state_d     = S_MAX_CAP;
			end
			S_MAX_CAP: begin
				cmd.cap_max = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

### sv/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: bounded ascending table of signed values
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// A word is taken when start is high while busy is low; busy then stays high
// until the result, shown for the single cycle in which done is high, and
// the receiver cannot stall it. A word that is not dropped walks the value
// memory one entry per read/check step through its single read port: an
// insert scans down from the last entry, a delete scans the whole occupied
// range, then both ends are read back for min and max, or both are cleared
// when the table is empty. A word is dropped, with no walk, when it inserts
// into a full table or deletes from an empty one or outside min and max;
// done comes in the cycle before the next word can be taken.
module sorted_list_insert_delete
	import slid_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic signed [31:0] min_value,
	output logic signed [31:0] max_value
);

	slid_cmd_t cmd;
	slid_sts_t sts;

	// sequencer
	slid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	// storage and compare
	slid_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_type  (req_type),
		.value     (value),
		.status    (status),
		.count     (count),
		.min_value (min_value),
		.max_value (max_value)
	);

endmodule

### sv/slid_check.sv
// ----------------------------------------------------------------------------
// slid_check: port-level checks of the sorted list
// Watches the command handshake and the result word over time.
// ----------------------------------------------------------------------------
module slid_check
	import slid_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] min_value,
	input logic signed [31:0] max_value
);

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// a result only comes while a word is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word while idle");

	// the block is free right after a result
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy after result word");

	// after an insert the table is ordered at its ends
	a_ins_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_INSERTED) |-> min_value <= max_value)
		else $error("min above max after insert");

endmodule

bind sorted_list_insert_delete slid_check u_slid_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.min_value (min_value),
	.max_value (max_value)
);

### sim/sorted_list_insert_delete_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_tb: self-checking bench for the sorted list
// Sends insert and delete words through the start/busy handshake and checks
// each done word against a local copy of the ascending table. A short
// directed run covers the corner cases, then random bursts swing the table
// between empty and full.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
	import slid_pkg::*;

	localparam int DEPTH      = 16;
	localparam int STALL_MAX  = 2000;
	localparam int DRAIN_WAIT = 60;
	localparam int N_RANDOM   = 1020;

	// one request word waiting to be sent
	typedef struct {
		logic               req;
		logic signed [31:0] val;
		int unsigned        gap_pct;
	} list_word_t;

	// one result word as the block should report it
	typedef struct {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] min_v;
		logic signed [31:0] max_v;
	} list_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               req_type = 1'b0;
	logic signed [31:0] value = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [4:0]         count;
	logic signed [31:0] min_value;
	logic signed [31:0] max_value;

	list_word_t         words_to_send[$];
	list_report_t       reports_due[$];
	logic signed [31:0] inserted_hist[$];
	logic signed [31:0] shadow_tbl[DEPTH];
	int                 shadow_cnt = 0;
	bit                 failed = 1'b0;
	int                 stall_cnt = 0;

	sorted_list_insert_delete #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.value     (value),
		.done      (done),
		.status    (status),
		.count     (count),
		.min_value (min_value),
		.max_value (max_value)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// apply one word to the shadow table and return the report it yields
	function automatic list_report_t list_apply(logic req, logic signed [31:0] v);
		list_report_t r;
		int           pos;
		r.status = ST_MISS;
		if (req == REQ_INSERT) begin
			if (shadow_cnt >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_cnt && shadow_tbl[pos] < v)
					pos++;
				for (int i = shadow_cnt; i > pos; i--)
					shadow_tbl[i] = shadow_tbl[i-1];
				shadow_tbl[pos] = v;
				shadow_cnt++;
				r.status = ST_INSERTED;
			end
		end else if (shadow_cnt > 0 && v >= shadow_tbl[0] && v <= shadow_tbl[shadow_cnt-1]) begin
			pos = 0;
			while (pos < shadow_cnt && shadow_tbl[pos] != v)
				pos++;
			if (pos < shadow_cnt) begin
				for (int i = pos; i < shadow_cnt - 1; i++)
					shadow_tbl[i] = shadow_tbl[i+1];
				shadow_cnt--;
				r.status = ST_REMOVED;
			end
		end
		r.count = 5'(shadow_cnt);
		r.min_v = (shadow_cnt > 0) ? shadow_tbl[0] : 32'sd0;
		r.max_v = (shadow_cnt > 0) ? shadow_tbl[shadow_cnt-1] : 32'sd0;
		return r;
	endfunction

	task automatic queue_word(logic req, logic signed [31:0] v, int unsigned gap);
		list_word_t w;
		w.req = req;
		w.val = v;
		w.gap_pct = gap;
		words_to_send.push_back(w);
		if (req == REQ_INSERT) begin
			inserted_hist.push_back(v);
			if (inserted_hist.size() > 32)
				void'(inserted_hist.pop_front());
		end
	endtask

	// half the time a small pool, so duplicates and hits are common
	function automatic logic signed [31:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 32'sd0 + $signed($urandom_range(0, 20)) - 32'sd10;
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh7ffffffe;
			3: return 32'sh80000001;
			4: return -32'sd1;
			default: return $signed($urandom());
		endcase
	endfunction

	// stimulus, reset and end of run
	initial begin
		int unsigned gap;
		int unsigned ins_pct;
		int          burst;
		int          sent;
		logic signed [31:0] v;

		// directed corner cases
		queue_word(REQ_DELETE, 32'sd7, 22);            // delete from empty
		queue_word(REQ_INSERT, 32'sd5, 22);
		queue_word(REQ_DELETE, 32'sd5, 22);            // only element goes
		queue_word(REQ_INSERT, 32'sh7fffffff, 22);
		queue_word(REQ_INSERT, 32'sh80000000, 22);
		queue_word(REQ_INSERT, 32'sd5, 22);
		queue_word(REQ_INSERT, 32'sd5, 22);            // duplicate
		queue_word(REQ_DELETE, 32'sd6, 22);            // in range, absent
		queue_word(REQ_DELETE, 32'sd5, 22);
		queue_word(REQ_DELETE, 32'sh7fffffff, 22);
		queue_word(REQ_DELETE, 32'sh80000000, 22);
		queue_word(REQ_DELETE, 32'sd9, 22);            // above max
		queue_word(REQ_DELETE, 32'sd1, 22);            // below min
		for (int i = 0; i < DEPTH - 1; i++)
			queue_word(REQ_INSERT, $signed(32'(i * 37 - 200)), 22);
		queue_word(REQ_INSERT, 32'sd3, 22);            // table full

		// random bursts leaning toward insert, toward delete or balanced
		sent = 0;
		while (sent < N_RANDOM) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 80;
				1: ins_pct = 50;
				default: ins_pct = 20;
			endcase
			burst = $urandom_range(5, 30);
			for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
				if (sent < N_RANDOM / 3)
					gap = 22;
				else if (sent < 2 * N_RANDOM / 3)
					gap = 72;
				else
					gap = 0;
				if ($urandom_range(0, 99) < ins_pct) begin
					queue_word(REQ_INSERT, pick_value(), gap);
				end else begin
					if (inserted_hist.size() > 0 && $urandom_range(0, 99) < 40)
						v = inserted_hist[$urandom_range(0, inserted_hist.size() - 1)];
					else
						v = pick_value();
					queue_word(REQ_DELETE, v, gap);
				end
				sent++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every word to go out and every report to come back
		do @(posedge clk);
		while (words_to_send.size() != 0 || start || reports_due.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (!failed)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// driver: one word per handshake, random gaps per phase
	always @(posedge clk) begin : drive
		list_word_t   w;
		list_report_t r;
		if (arst_n) begin
			if (start && !busy) begin
				w = words_to_send.pop_front();
				r = list_apply(w.req, w.val);
				reports_due.push_back(r);
			end
			// hold the word while the block is busy
			if (!(start && busy)) begin
				if (words_to_send.size() != 0 &&
				    $urandom_range(0, 99) >= words_to_send[0].gap_pct) begin
					start    <= 1'b1;
					req_type <= words_to_send[0].req;
					value    <= words_to_send[0].val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each done word with the oldest expected report
	always @(posedge clk) begin : monitor
		list_report_t r;
		if (arst_n && done) begin
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected word status=%0d count=%0d min=%0d max=%0d",
					$time, status, count, min_value, max_value);
				failed = 1'b1;
			end else begin
				r = reports_due.pop_front();
				if (status !== r.status) begin
					$display("%0t: status expected %0d actual %0d", $time, r.status, status);
					failed = 1'b1;
				end
				if (count !== r.count) begin
					$display("%0t: count expected %0d actual %0d", $time, r.count, count);
					failed = 1'b1;
				end
				if (min_value !== r.min_v) begin
					$display("%0t: min_value expected %0d actual %0d", $time, r.min_v, min_value);
					failed = 1'b1;
				end
				if (max_value !== r.max_v) begin
					$display("%0t: max_value expected %0d actual %0d", $time, r.max_v, max_value);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no handshake and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_MAX);
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

### sim.f
sv/slid_pkg.sv
sv/slid_datapath.sv
sv/slid_ctrl.sv
sv/sorted_list_insert_delete.sv
sv/slid_check.sv
sim/sorted_list_insert_delete_tb.sv
